@@ hw/rtl/exlx_pkg.sv @@
// Shared types, constants and character-class helpers for the expression lexer.
// No dependencies; used by exlx_scanner, exlx_tok_fifo and expression_lexer.
package exlx_pkg;

	// Line position and run length width; both saturate at all ones
	localparam int POS_BITS = 16;
	// Width of the start and length fields on the result stream
	localparam int LEX_BITS = 16;
	// Keyword characters kept from a letter run
	localparam int KW_MAX_CHARS = 8;
	localparam int KW_BITS = 8 * KW_MAX_CHARS;
	localparam int KW_IDX_BITS = (KW_MAX_CHARS > 1) ? $clog2(KW_MAX_CHARS) : 1;
	localparam int KW_LEN_BITS = 4;
	// Result item buffer depth
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);

	localparam logic [POS_BITS-1:0] POS_MAX = '1;

	// Input item op codes
	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_END = 1'b1;

	// Register indexes (paddr[4:3])
	localparam logic [1:0] REG_LET_KW = 2'd0;
	localparam logic [1:0] REG_LET_LEN = 2'd1;
	localparam logic [1:0] REG_PRINT_KW = 2'd2;
	localparam logic [1:0] REG_PRINT_LEN = 2'd3;

	// Register reset values
	localparam logic [KW_BITS-1:0] LET_KW_RST = 64'd478560543085;
	localparam logic [KW_BITS-1:0] PRINT_KW_RST = 64'd478626801763;
	localparam logic [KW_LEN_BITS-1:0] KW_LEN_RST = 4'd5;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_WORD = 2'd1,
		MODE_NUM  = 2'd2
	} mode_t;

	typedef enum logic [3:0] {
		KIND_NUMBER    = 4'd0,
		KIND_IDENT     = 4'd1,
		KIND_LET       = 4'd2,
		KIND_PRINT     = 4'd3,
		KIND_PLUS      = 4'd4,
		KIND_MINUS     = 4'd5,
		KIND_SLASH     = 4'd6,
		KIND_STAR      = 4'd7,
		KIND_LPAREN    = 4'd8,
		KIND_RPAREN    = 4'd9,
		KIND_END       = 4'd10,
		KIND_UNKNOWN   = 4'd11,
		KIND_SEMICOLON = 4'd12,
		KIND_EQUAL     = 4'd13
	} kind_t;

	typedef struct packed {
		kind_t               kind;
		logic [LEX_BITS-1:0] start;
		logic [LEX_BITS-1:0] length;
		logic [7:0]          sym;
		logic                last;
	} token_t;

	typedef struct packed {
		logic [KW_BITS-1:0]     let_kw;
		logic [KW_LEN_BITS-1:0] let_len;
		logic [KW_BITS-1:0]     print_kw;
		logic [KW_LEN_BITS-1:0] print_len;
	} cfg_t;

	function automatic logic is_letter(logic [7:0] b);
		return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
	endfunction

	function automatic logic is_digit(logic [7:0] b);
		return b >= 8'h30 && b <= 8'h39;
	endfunction

	function automatic logic is_space(logic [7:0] b);
		return b == 8'h20 || (b >= 8'h09 && b <= 8'h0D);
	endfunction

	function automatic kind_t symbol_kind(logic [7:0] b);
		kind_t k;
		unique case (b)
			8'h2B:   k = KIND_PLUS;
			8'h2D:   k = KIND_MINUS;
			8'h2F:   k = KIND_SLASH;
			8'h2A:   k = KIND_STAR;
			8'h28:   k = KIND_LPAREN;
			8'h29:   k = KIND_RPAREN;
			8'h3B:   k = KIND_SEMICOLON;
			8'h3D:   k = KIND_EQUAL;
			default: k = KIND_UNKNOWN;
		endcase
		return k;
	endfunction

	// Compare the kept prefix of a run with a keyword of klen characters
	function automatic logic kw_match(logic [KW_BITS-1:0] prefix,
			logic [POS_BITS-1:0] rlen, logic [KW_BITS-1:0] kw,
			logic [KW_LEN_BITS-1:0] klen);
		logic ok;
		ok = (klen != '0) && (klen <= KW_LEN_BITS'(KW_MAX_CHARS))
			&& (rlen == POS_BITS'(klen));
		for (int i = 0; i < KW_MAX_CHARS; i++) begin
			if (i < int'(klen) && prefix[8*i +: 8] != kw[8*i +: 8])
				ok = 1'b0;
		end
		return ok;
	endfunction

endpackage

@@ hw/rtl/exlx_scanner.sv @@
// Scan state and token formation: one input item in, up to two tokens out.
// Depends on exlx_pkg.
module exlx_scanner (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  logic                op,
	input  logic [7:0]          src,
	input  exlx_pkg::cfg_t      cfg,
	output exlx_pkg::token_t    tok0,
	output exlx_pkg::token_t    tok1,
	output logic [1:0]          push_n
);

	exlx_pkg::mode_t                 mode_q, mode_d;
	logic [exlx_pkg::KW_BITS-1:0]    prefix_q, prefix_d;
	logic [exlx_pkg::POS_BITS-1:0]   start_q, start_d;
	logic [exlx_pkg::POS_BITS-1:0]   len_q, len_d;
	logic [exlx_pkg::POS_BITS-1:0]   pos_q, pos_d;

	logic is_end, letter, digit, space, cont, flush_v, second_v;
	exlx_pkg::kind_t  word_kind;
	exlx_pkg::token_t flush_tok, second_tok;

	// Classify the incoming byte against the current run
	assign is_end = (op == exlx_pkg::OP_END);
	assign letter = exlx_pkg::is_letter(src);
	assign digit = exlx_pkg::is_digit(src);
	assign space = exlx_pkg::is_space(src);
	assign cont = !is_end && ((mode_q == exlx_pkg::MODE_WORD && letter)
		|| (mode_q == exlx_pkg::MODE_NUM && digit));
	assign flush_v = (mode_q != exlx_pkg::MODE_IDLE) && !cont;
	assign second_v = is_end || (!letter && !digit && !space);

	// Next state
	always_comb begin
		mode_d = mode_q;
		prefix_d = prefix_q;
		start_d = start_q;
		len_d = len_q;
		pos_d = pos_q;
		if (is_end) begin
			mode_d = exlx_pkg::MODE_IDLE;
			prefix_d = '0;
			len_d = '0;
			start_d = '0;
			pos_d = '0;
		end else begin
			if (pos_q != exlx_pkg::POS_MAX)
				pos_d = pos_q + 1'b1;
			if (cont) begin
				if (mode_q == exlx_pkg::MODE_WORD
						&& len_q < exlx_pkg::POS_BITS'(exlx_pkg::KW_MAX_CHARS))
					prefix_d = prefix_q | ({{(exlx_pkg::KW_BITS-8){1'b0}}, src}
						<< {len_q[exlx_pkg::KW_IDX_BITS-1:0], 3'b000});
				if (len_q != exlx_pkg::POS_MAX)
					len_d = len_q + 1'b1;
			end else if (letter) begin
				mode_d = exlx_pkg::MODE_WORD;
				prefix_d = {{(exlx_pkg::KW_BITS-8){1'b0}}, src};
				start_d = pos_q;
				len_d = exlx_pkg::POS_BITS'(1);
			end else if (digit) begin
				mode_d = exlx_pkg::MODE_NUM;
				prefix_d = '0;
				start_d = pos_q;
				len_d = exlx_pkg::POS_BITS'(1);
			end else begin
				mode_d = exlx_pkg::MODE_IDLE;
				prefix_d = '0;
				len_d = '0;
			end
		end
	end

	// Token outputs
	always_comb begin
		if (exlx_pkg::kw_match(prefix_q, len_q, cfg.let_kw, cfg.let_len))
			word_kind = exlx_pkg::KIND_LET;
		else if (exlx_pkg::kw_match(prefix_q, len_q, cfg.print_kw, cfg.print_len))
			word_kind = exlx_pkg::KIND_PRINT;
		else
			word_kind = exlx_pkg::KIND_IDENT;

		flush_tok.kind = (mode_q == exlx_pkg::MODE_WORD) ? word_kind
			: exlx_pkg::KIND_NUMBER;
		flush_tok.start = exlx_pkg::LEX_BITS'(start_q);
		flush_tok.length = exlx_pkg::LEX_BITS'(len_q);
		flush_tok.sym = '0;
		flush_tok.last = !second_v;

		if (is_end) begin
			second_tok.kind = exlx_pkg::KIND_END;
			second_tok.length = '0;
			second_tok.sym = '0;
		end else begin
			second_tok.kind = exlx_pkg::symbol_kind(src);
			second_tok.length = exlx_pkg::LEX_BITS'(1);
			second_tok.sym = src;
		end
		second_tok.start = exlx_pkg::LEX_BITS'(pos_q);
		second_tok.last = 1'b1;

		tok0 = flush_v ? flush_tok : second_tok;
		tok1 = second_tok;
		if (!fire)
			push_n = 2'd0;
		else
			push_n = {1'b0, flush_v} + {1'b0, second_v};
	end

	// Hold state between transactions, advance on each one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= exlx_pkg::MODE_IDLE;
			prefix_q <= '0;
			start_q <= '0;
			len_q <= '0;
			pos_q <= '0;
		end else if (fire) begin
			mode_q <= mode_d;
			prefix_q <= prefix_d;
			start_q <= start_d;
			len_q <= len_d;
			pos_q <= pos_d;
		end
	end

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == exlx_pkg::MODE_IDLE |-> len_q == '0 && prefix_q == '0)
		else $error("idle scanner holds a pending run");

	a_run_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q != exlx_pkg::MODE_IDLE |-> len_q != '0)
		else $error("open run with zero length");

	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		fire && is_end |-> push_n != 2'd0
			&& (push_n == 2'd1 ? tok0.kind : tok1.kind) == exlx_pkg::KIND_END)
		else $error("end of line did not close with an END token");

endmodule

@@ hw/rtl/exlx_tok_fifo.sv @@
// Token buffer between the scanner and the result stream; takes up to two tokens a cycle.
// Depends on exlx_pkg.
module exlx_tok_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [1:0]          push_n,
	input  exlx_pkg::token_t    push_tok0,
	input  exlx_pkg::token_t    push_tok1,
	input  logic                out_ready,
	output logic                out_valid,
	output exlx_pkg::token_t    out_tok,
	output logic                room
);

	exlx_pkg::token_t                    mem [exlx_pkg::FIFO_DEPTH];
	logic [exlx_pkg::FIFO_PTR_BITS-1:0]  wr_q, rd_q;
	logic [exlx_pkg::FIFO_PTR_BITS:0]    count_q;
	logic                                pop;
	logic [exlx_pkg::FIFO_PTR_BITS-1:0]  wr_next;

	assign out_valid = (count_q != '0);
	assign out_tok = mem[rd_q];
	assign pop = out_valid && out_ready;
	// Room for a full two-token transaction
	assign room = count_q <= (exlx_pkg::FIFO_PTR_BITS+1)'(exlx_pkg::FIFO_DEPTH - 2);
	assign wr_next = wr_q + 1'b1;

	// Write entries
	always_ff @(posedge clk) begin
		if (push_n != 2'd0)
			mem[wr_q] <= push_tok0;
		if (push_n == 2'd2)
			mem[wr_next] <= push_tok1;
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			wr_q <= wr_q + exlx_pkg::FIFO_PTR_BITS'(push_n);
			if (pop)
				rd_q <= rd_q + 1'b1;
			count_q <= count_q + (exlx_pkg::FIFO_PTR_BITS+1)'(push_n)
				- (exlx_pkg::FIFO_PTR_BITS+1)'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push_n != 2'd0 |-> room)
		else $error("token push without room");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (exlx_pkg::FIFO_PTR_BITS+1)'(exlx_pkg::FIFO_DEPTH))
		else $error("token count beyond depth");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == 1 && pop && push_n == 2'd0 |=> !out_valid)
		else $error("buffer not empty after last token left");

endmodule

@@ hw/rtl/expression_lexer.sv @@
// Expression lexer top level: input stage, configuration registers, scanner, token buffer.
// Depends on exlx_pkg, exlx_scanner and exlx_tok_fifo.
//
//  channel   direction  fields (low bit first)
//  s_*       in         tuser: op; tdata: source_byte
//  m_*       out        tuser: token_kind; tdata: lexeme_start, lexeme_length,
//                       symbol_byte; tlast: last_of_run
//  APB       in/out     64-bit registers at 0x00, 0x08, 0x10, 0x18
//
// One input item per cycle: a byte is registered, then scanned combinationally into
// zero, one or two tokens that enter a four-entry token buffer.
// The output side drains one token per cycle while m_tready is high, so items that give
// two tokens fill the buffer faster than it drains.
// Input stalls only when the buffer has fewer than two free entries.
// Reset clears scan state, line position, buffer and restores the keywords.
module expression_lexer (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] source_byte
	input  logic        s_tuser,   // [0] op
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [15:0] lexeme_start, [31:16] lexeme_length, [39:32] symbol_byte
	output logic [3:0]  m_tuser,   // [3:0] token_kind
	output logic        m_tlast,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);

	exlx_pkg::cfg_t   cfg_q;
	logic             v_s1, op_s1, fire, room;
	logic [7:0]       byte_s1;
	exlx_pkg::token_t tok0, tok1, out_tok;
	logic [1:0]       push_n;
	logic             cfg_wr;

	// Configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.let_kw <= exlx_pkg::LET_KW_RST;
			cfg_q.let_len <= exlx_pkg::KW_LEN_RST;
			cfg_q.print_kw <= exlx_pkg::PRINT_KW_RST;
			cfg_q.print_len <= exlx_pkg::KW_LEN_RST;
		end else if (cfg_wr) begin
			unique case (paddr[4:3])
				exlx_pkg::REG_LET_KW:    cfg_q.let_kw <= pwdata;
				exlx_pkg::REG_LET_LEN:   cfg_q.let_len <= pwdata[exlx_pkg::KW_LEN_BITS-1:0];
				exlx_pkg::REG_PRINT_KW:  cfg_q.print_kw <= pwdata;
				exlx_pkg::REG_PRINT_LEN: cfg_q.print_len <= pwdata[exlx_pkg::KW_LEN_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:3])
			exlx_pkg::REG_LET_KW:    prdata = cfg_q.let_kw;
			exlx_pkg::REG_LET_LEN:   prdata = 64'(cfg_q.let_len);
			exlx_pkg::REG_PRINT_KW:  prdata = cfg_q.print_kw;
			exlx_pkg::REG_PRINT_LEN: prdata = 64'(cfg_q.print_len);
			default:                 prdata = '0;
		endcase
	end

	// Input stage: refill when empty or whenever the held item moves on
	assign fire = v_s1 && room;
	assign s_tready = !v_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (s_tready)
			v_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1 <= s_tuser;
			byte_s1 <= s_tdata;
		end
	end

	exlx_scanner u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.op     (op_s1),
		.src    (byte_s1),
		.cfg    (cfg_q),
		.tok0   (tok0),
		.tok1   (tok1),
		.push_n (push_n)
	);

	exlx_tok_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_n    (push_n),
		.push_tok0 (tok0),
		.push_tok1 (tok1),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_tok   (out_tok),
		.room      (room)
	);

	// Result stream packing
	assign m_tdata = {out_tok.sym, out_tok.length, out_tok.start};
	assign m_tuser = out_tok.kind;
	assign m_tlast = out_tok.last;

endmodule

@@ dv/expression_lexer_tb.sv @@
// Self-checking testbench for expression_lexer: byte stream in, token stream out.
// Depends on exlx_pkg and the expression_lexer RTL; predicts tokens on every accepted byte.
module expression_lexer_tb;

	typedef struct packed {
		logic       op;
		logic [7:0] b;
	} lex_in_t;

	typedef enum logic [1:0] {
		CH_LETTER,
		CH_DIGIT,
		CH_BLANK,
		CH_OTHER
	} ch_class_t;

	localparam int LONG_WORD = 40;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;
	logic        s_tuser = exlx_pkg::OP_BYTE;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic [3:0]  m_tuser;
	logic        m_tlast;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic        pready;

	expression_lexer u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #2 clk = ~clk;

	// Keyword registers as the lexer should hold them
	logic [63:0] kw_let = exlx_pkg::LET_KW_RST;
	logic [3:0]  kw_let_len = exlx_pkg::KW_LEN_RST;
	logic [63:0] kw_print = exlx_pkg::PRINT_KW_RST;
	logic [3:0]  kw_print_len = exlx_pkg::KW_LEN_RST;

	// Scanner state of the predictor
	exlx_pkg::mode_t lex_mode = exlx_pkg::MODE_IDLE;
	logic [63:0] word_bits = '0;
	logic [15:0] run_pos = '0;
	logic [15:0] run_len = '0;
	logic [15:0] line_pos = '0;

	lex_in_t           line_items[$];
	exlx_pkg::token_t  tokens_due[$];

	int errors = 0;
	int items_taken = 0;
	int tokens_checked = 0;
	int kw_tokens = 0;
	int pushed = 0;
	int cfg_sets = 0;

	// Pacing knobs, set by the stimulus process, and pacing counters kept by the driver and monitor
	logic        gaps_on = 1'b1;
	logic [15:0] stall_pat = '1;
	int          stall_len = 1;
	int          stall_idx = 0;
	int          burst_left = 0;
	int          gap_left = 0;

	logic [7:0] puncts [8] = '{8'h2B, 8'h2D, 8'h2F, 8'h2A, 8'h28, 8'h29, 8'h3B, 8'h3D};
	logic [7:0] blanks [6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};

	function automatic ch_class_t classify(input logic [7:0] b);
		if ((b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A))
			return CH_LETTER;
		if (b >= 8'h30 && b <= 8'h39)
			return CH_DIGIT;
		if (b == 8'h20 || (b >= 8'h09 && b <= 8'h0D))
			return CH_BLANK;
		return CH_OTHER;
	endfunction

	function automatic exlx_pkg::kind_t punct_kind(input logic [7:0] b);
		case (b)
			8'h2B:   return exlx_pkg::KIND_PLUS;
			8'h2D:   return exlx_pkg::KIND_MINUS;
			8'h2F:   return exlx_pkg::KIND_SLASH;
			8'h2A:   return exlx_pkg::KIND_STAR;
			8'h28:   return exlx_pkg::KIND_LPAREN;
			8'h29:   return exlx_pkg::KIND_RPAREN;
			8'h3B:   return exlx_pkg::KIND_SEMICOLON;
			8'h3D:   return exlx_pkg::KIND_EQUAL;
			default: return exlx_pkg::KIND_UNKNOWN;
		endcase
	endfunction

	function automatic exlx_pkg::token_t tok(input exlx_pkg::kind_t k, input logic [15:0] s,
			input logic [15:0] l, input logic [7:0] y);
		exlx_pkg::token_t t;
		t.kind = k;
		t.start = s;
		t.length = l;
		t.sym = y;
		t.last = 1'b0;
		return t;
	endfunction

	// Word matches a keyword: exact length, lower klen bytes equal
	function automatic logic kw_hit(input logic [63:0] kw, input logic [3:0] klen);
		logic [63:0] mask;
		if (klen == 0 || klen > exlx_pkg::KW_MAX_CHARS || run_len != 16'(klen))
			return 1'b0;
		mask = (klen >= 8) ? '1 : ((64'd1 << (8 * klen)) - 64'd1);
		return ((word_bits ^ kw) & mask) == '0;
	endfunction

	// Emit the pending word or number, if any
	function automatic void close_run();
		exlx_pkg::kind_t k;
		if (lex_mode == exlx_pkg::MODE_IDLE)
			return;
		if (lex_mode == exlx_pkg::MODE_NUM)
			k = exlx_pkg::KIND_NUMBER;
		else if (kw_hit(kw_let, kw_let_len))
			k = exlx_pkg::KIND_LET;
		else if (kw_hit(kw_print, kw_print_len))
			k = exlx_pkg::KIND_PRINT;
		else
			k = exlx_pkg::KIND_IDENT;
		tokens_due.insert(tokens_due.size(), tok(k, run_pos, run_len, 8'h00));
		lex_mode = exlx_pkg::MODE_IDLE;
		word_bits = '0;
		run_len = '0;
	endfunction

	function automatic void grow_run(input logic [7:0] b);
		if (lex_mode == exlx_pkg::MODE_WORD && run_len < exlx_pkg::KW_MAX_CHARS)
			word_bits[8 * run_len +: 8] = b;
		if (run_len != exlx_pkg::POS_MAX)
			run_len++;
	endfunction

	// Work out the tokens caused by one accepted item
	function automatic void scan_item(input logic op, input logic [7:0] b);
		int          n0;
		logic [15:0] here;
		ch_class_t   c;
		n0 = tokens_due.size();
		here = line_pos;
		c = classify(b);
		if (op == exlx_pkg::OP_END) begin
			close_run();
			tokens_due.insert(tokens_due.size(),
				tok(exlx_pkg::KIND_END, here, 16'd0, 8'h00));
			line_pos = '0;
			run_pos = '0;
		end else begin
			if (line_pos != exlx_pkg::POS_MAX)
				line_pos++;
			if ((lex_mode == exlx_pkg::MODE_WORD && c == CH_LETTER) ||
					(lex_mode == exlx_pkg::MODE_NUM && c == CH_DIGIT)) begin
				grow_run(b);
			end else begin
				close_run();
				if (c == CH_LETTER || c == CH_DIGIT) begin
					lex_mode = (c == CH_LETTER) ? exlx_pkg::MODE_WORD : exlx_pkg::MODE_NUM;
					word_bits = '0;
					run_pos = here;
					run_len = '0;
					grow_run(b);
				end else if (c == CH_OTHER) begin
					tokens_due.insert(tokens_due.size(), tok(punct_kind(b), here, 16'd1, b));
				end
			end
		end
		if (tokens_due.size() > n0)
			tokens_due[tokens_due.size() - 1].last = 1'b1;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		if (errors < 40)
			$display("[%0t] mismatch %s: got %0h, expected %0h (token %0d)",
				$time, what, got, want, tokens_checked);
		errors++;
	endtask

	// Drive the input stream: bursts of transactions separated by random gaps when gaps_on is set
	always @(posedge clk) begin : drv
		lex_in_t nxt;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				scan_item(s_tuser, s_tdata);
				items_taken++;
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (line_items.size() > 0) begin
					nxt = line_items.pop_front();
					s_tvalid <= 1'b1;
					s_tuser <= nxt.op;
					s_tdata <= nxt.b;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 32);
						if (!gaps_on)
							gap_left = 0;
						else if ($urandom_range(0, 4) == 0)
							gap_left = $urandom_range(4, 12);
						else
							gap_left = $urandom_range(0, 2);
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Check each token transaction against the oldest expectation and pace m_tready from the stall pattern
	always @(posedge clk) begin : mon
		exlx_pkg::token_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (tokens_due.size() == 0) begin
					report_mismatch("unexpected token kind", 64'(m_tuser), 64'd0);
				end else begin
					want = tokens_due.pop_front();
					if (m_tuser !== want.kind)
						report_mismatch("token_kind", 64'(m_tuser), 64'(want.kind));
					if (m_tdata[15:0] !== want.start)
						report_mismatch("lexeme_start", 64'(m_tdata[15:0]), 64'(want.start));
					if (m_tdata[31:16] !== want.length)
						report_mismatch("lexeme_length", 64'(m_tdata[31:16]), 64'(want.length));
					if (m_tdata[39:32] !== want.sym)
						report_mismatch("symbol_byte", 64'(m_tdata[39:32]), 64'(want.sym));
					if (m_tlast !== want.last)
						report_mismatch("last_of_run", 64'(m_tlast), 64'(want.last));
					if (want.kind == exlx_pkg::KIND_LET || want.kind == exlx_pkg::KIND_PRINT)
						kw_tokens++;
				end
				tokens_checked++;
			end
			m_tready <= stall_pat[stall_idx];
			stall_idx = (stall_idx + 1 >= stall_len) ? 0 : stall_idx + 1;
		end
	end

	task automatic push_byte(input logic [7:0] b);
		line_items.insert(line_items.size(), '{op: exlx_pkg::OP_BYTE, b: b});
		pushed++;
	endtask

	task automatic push_end();
		line_items.insert(line_items.size(),
			'{op: exlx_pkg::OP_END, b: 8'($urandom_range(0, 255))});
		pushed++;
	endtask

	function automatic logic [7:0] rand_letter();
		int r;
		r = $urandom_range(0, 51);
		return (r < 26) ? 8'(8'h41 + r) : 8'(8'h61 + r - 26);
	endfunction

	function automatic logic [63:0] rand_kw(input int len);
		logic [63:0] w;
		w = {$urandom, $urandom};
		for (int i = 0; i < len && i < 8; i++)
			w[8 * i +: 8] = rand_letter();
		return w;
	endfunction

	// Keyword text exactly, one letter longer, or one letter short
	task automatic push_kw(input logic [63:0] kw, input logic [3:0] klen);
		int n;
		int variant;
		n = (klen == 0) ? 3 : ((klen > 8) ? 8 : klen);
		variant = $urandom_range(0, 5);
		if (variant == 5 && n > 1)
			n--;
		for (int i = 0; i < n; i++)
			push_byte(kw[8 * i +: 8]);
		if (variant == 4)
			push_byte(rand_letter());
	endtask

	// One line of mostly well-formed tokens with some noise, closed by an end of line
	task automatic add_line(input int words);
		int pick;
		repeat (words) begin
			pick = $urandom_range(0, 99);
			if (pick < 15)
				push_kw(kw_let, kw_let_len);
			else if (pick < 27)
				push_kw(kw_print, kw_print_len);
			else if (pick < 45)
				repeat ($urandom_range(1, 12)) push_byte(rand_letter());
			else if (pick < 60)
				repeat ($urandom_range(1, 6)) push_byte(8'(8'h30 + $urandom_range(0, 9)));
			else if (pick < 85)
				push_byte(puncts[$urandom_range(0, 7)]);
			else if (pick < 92)
				push_byte(blanks[$urandom_range(0, 5)]);
			else
				push_byte(8'($urandom_range(0, 255)));
			if ($urandom_range(0, 1) == 0)
				push_byte(8'h20);
		end
		push_end();
	endtask

	task automatic fill_random(input int count);
		int first;
		first = pushed;
		while (pushed - first < count)
			add_line($urandom_range(0, 10));
	endtask

	task automatic pick_pace();
		gaps_on = ($urandom_range(0, 3) != 0);
		stall_len = $urandom_range(3, 16);
		stall_pat = ($urandom_range(0, 3) == 0) ? '1 : (16'($urandom) | 16'h0001);
	endtask

	// Hold until every pending item is taken and every token has arrived
	task automatic wait_idle();
		do @(posedge clk);
		while (line_items.size() != 0 || s_tvalid || tokens_due.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [1:0] idx, input logic [63:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			exlx_pkg::REG_LET_KW:    kw_let = val;
			exlx_pkg::REG_LET_LEN:   kw_let_len = val[3:0];
			exlx_pkg::REG_PRINT_KW:  kw_print = val;
			exlx_pkg::REG_PRINT_LEN: kw_print_len = val[3:0];
			default: ;
		endcase
	endtask

	task automatic set_keywords(input logic [63:0] lw, input logic [3:0] ll,
			input logic [63:0] pw, input logic [3:0] pl);
		cfg_write(exlx_pkg::REG_LET_KW, lw);
		cfg_write(exlx_pkg::REG_LET_LEN, {$urandom, 28'($urandom), ll});
		cfg_write(exlx_pkg::REG_PRINT_KW, pw);
		cfg_write(exlx_pkg::REG_PRINT_LEN, {60'd0, pl});
		cfg_sets++;
	endtask

	initial begin : stim
		logic [63:0] w;
		int          len;
		string       txt;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: reset keywords, every punctuation kind, empty line, byte extremes
		txt = "manlo=x+(12)*b/-3;";
		for (int i = 0; i < txt.len(); i++)
			push_byte(txt[i]);
		push_end();
		push_end();
		push_byte(8'h00);
		push_byte(8'hFF);
		push_byte(8'h09);
		push_byte(8'h0D);
		txt = "chapo";
		for (int i = 0; i < txt.len(); i++)
			push_byte(txt[i]);
		push_end();
		wait_idle();

		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				0: set_keywords('0, 4'd0, '1, 4'd15);
				1: set_keywords(rand_kw(8), 4'd8, rand_kw(8), 4'd8);
				2: begin
					len = $urandom_range(1, 8);
					w = rand_kw(len);
					set_keywords(w, 4'(len), w, 4'(len));
				end
				3: set_keywords(rand_kw(8), 4'd9, rand_kw(1), 4'd1);
				default: begin
					len = $urandom_range(1, 8);
					set_keywords(rand_kw(len), 4'(len), rand_kw(8),
						4'($urandom_range(0, 3) == 0 ? $urandom_range(0, 15)
							: $urandom_range(1, 8)));
				end
			endcase
			pick_pace();
			fill_random(75);
			// pause the sender until all tokens are back
			wait_idle();
			pick_pace();
			fill_random(75);
			wait_idle();
		end

		// One long word well past the kept keyword prefix, then a short tail
		gaps_on = 1'b0;
		stall_pat = '1;
		repeat (LONG_WORD) push_byte(rand_letter());
		push_byte(8'h2B);
		push_byte(8'h61);
		push_byte(8'h37);
		push_end();
		wait_idle();

		$display("Covered %0d input items under %0d keyword settings plus reset values;",
			items_taken, cfg_sets);
		$display("checked %0d tokens (%0d keywords), including a %0d-letter word.",
			tokens_checked, kw_tokens, LONG_WORD);
		if (errors == 0)
			$display("PASS expression_lexer");
		else
			$display("FAIL expression_lexer");
		$finish;
	end

	// Watchdog
	initial begin
		#4000000;
		$display("FAIL expression_lexer");
		$finish;
	end

endmodule
